### src/tccs_pkg.sv
// ============================================================================
// tccs_pkg - text console shared definitions
// screen geometry, request and command codes, back-end states
// ============================================================================
`default_nettype none

package tccs_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    // field widths
    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int REQ_W    = 2;

    // derived positions
    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST     = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] CELL_LIMIT    = ADDR_W'(CELL_COUNT);

    // character and attribute constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE  = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE    = 8'h20;
    localparam logic [ATTR_W-1:0] DEFAULT_COLOR = 8'h07;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_index;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### src/tccs_front.sv
// ============================================================================
// tccs_front - request intake
// accepts requests and classifies them into back-end commands
// ============================================================================
`default_nettype none

module tccs_front
(
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [tccs_pkg::REQ_W-1:0]   req_type,
    input  wire logic [tccs_pkg::CHAR_W-1:0]  char_code,
    input  wire logic [tccs_pkg::ADDR_W-1:0]  cell_index,
    input  wire logic                         q_full,
    input  wire logic                         hold,
    output logic                              push,
    output tccs_pkg::cmd_t                    cmd
);

    // no intake while the queue is full or the store is being initialized
    assign in_stall = q_full || hold;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        cmd.char_code  = char_code;
        cmd.cell_index = cell_index;
        unique case (req_type)
            tccs_pkg::REQ_PUT:
            begin
                cmd.op = (char_code == tccs_pkg::NEWLINE_CODE) ?
                         tccs_pkg::OP_NEWLINE : tccs_pkg::OP_PUT;
            end
            tccs_pkg::REQ_CLEAR:
            begin
                cmd.op = tccs_pkg::OP_CLEAR;
            end
            tccs_pkg::REQ_READ:
            begin
                // out of range reads return zero, like an unused code
                cmd.op = (cell_index < tccs_pkg::CELL_LIMIT) ?
                         tccs_pkg::OP_READ : tccs_pkg::OP_NOP;
            end
            default:
            begin
                cmd.op = tccs_pkg::OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/tccs_queue.sv
// ============================================================================
// tccs_queue - command queue
// short fifo that decouples request intake from command execution
// ============================================================================
`default_nettype none

module tccs_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tccs_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output logic                 not_empty,
    output logic                 full,
    output tccs_pkg::cmd_t       head_cmd
);

    tccs_pkg::cmd_t                 entry_reg [tccs_pkg::QUEUE_DEPTH];
    logic [tccs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tccs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tccs_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == tccs_pkg::QCNT_W'(tccs_pkg::QUEUE_DEPTH));
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### src/tccs_back.sv
// ============================================================================
// tccs_back - command execution
// owns the screen store and cursor, runs puts, reads, clears and scrolls
// ============================================================================
`default_nettype none

module tccs_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    input  wire tccs_pkg::cmd_t               cmd,
    output logic                              cmd_pop,
    input  wire logic [tccs_pkg::ATTR_W-1:0]  text_color,
    output logic                              init_busy,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [tccs_pkg::ROW_W-1:0]        cursor_row,
    output logic [tccs_pkg::COL_W-1:0]        cursor_col,
    output logic [tccs_pkg::CELL_W-1:0]       cell_value,
    output logic                              scrolled
);

    // screen store, one write and one registered read per cycle
    logic [tccs_pkg::CELL_W-1:0] cell_mem [tccs_pkg::CELL_COUNT];
    logic [tccs_pkg::CELL_W-1:0] mem_rdata_reg;
    logic                        mem_we;
    logic [tccs_pkg::ADDR_W-1:0] mem_waddr;
    logic [tccs_pkg::ADDR_W-1:0] mem_raddr;
    logic [tccs_pkg::CELL_W-1:0] mem_wdata;

    tccs_pkg::back_state_t       state_reg, state_next;
    logic [tccs_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tccs_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tccs_pkg::ADDR_W-1:0] scan_reg, scan_next;
    logic                        copy_pend_reg, copy_pend_next;
    logic [tccs_pkg::ADDR_W-1:0] copy_addr_reg, copy_addr_next;
    logic [tccs_pkg::ATTR_W-1:0] fill_attr_reg, fill_attr_next;
    logic                        fill_emit_reg, fill_emit_next;
    logic [tccs_pkg::CELL_W-1:0] res_cell_reg, res_cell_next;
    logic                        res_scroll_reg, res_scroll_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tccs_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [tccs_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [tccs_pkg::CELL_W-1:0] out_cell_reg, out_cell_next;
    logic                        out_scroll_reg, out_scroll_next;
    logic [tccs_pkg::ADDR_W-1:0] cursor_addr;

    assign cursor_addr = tccs_pkg::ADDR_W'(row_reg) * tccs_pkg::ROW_STRIDE
                       + tccs_pkg::ADDR_W'(col_reg);

    assign init_busy  = (state_reg == tccs_pkg::ST_FILL) && !fill_emit_reg;
    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign cell_value = out_cell_reg;
    assign scrolled   = out_scroll_reg;

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        scan_next       = scan_reg;
        copy_pend_next  = copy_pend_reg;
        copy_addr_next  = copy_addr_reg;
        fill_attr_next  = fill_attr_reg;
        fill_emit_next  = fill_emit_reg;
        res_cell_next   = res_cell_reg;
        res_scroll_next = res_scroll_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_cell_next   = out_cell_reg;
        out_scroll_next = out_scroll_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = {fill_attr_reg, tccs_pkg::BLANK_CODE};
        mem_raddr       = cmd.cell_index;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            tccs_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    res_cell_next   = '0;
                    res_scroll_next = 1'b0;
                    state_next      = tccs_pkg::ST_EMIT;
                    unique case (cmd.op) inside
                        tccs_pkg::OP_PUT,
                        tccs_pkg::OP_NEWLINE:
                        begin
                            if (cmd.op == tccs_pkg::OP_PUT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_addr;
                                mem_wdata = {text_color, cmd.char_code};
                            end
                            if ((cmd.op == tccs_pkg::OP_NEWLINE) ||
                                (col_reg == tccs_pkg::COL_LAST))
                            begin
                                col_next = '0;
                                if (row_reg == tccs_pkg::ROW_LAST)
                                begin
                                    // ran off the bottom: scroll up one row
                                    res_scroll_next = 1'b1;
                                    scan_next       = tccs_pkg::ROW_STRIDE;
                                    copy_pend_next  = 1'b0;
                                    state_next      = tccs_pkg::ST_COPY;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        tccs_pkg::OP_CLEAR:
                        begin
                            row_next       = '0;
                            col_next       = '0;
                            scan_next      = '0;
                            copy_pend_next = 1'b0;
                            fill_attr_next = text_color;
                            fill_emit_next = 1'b1;
                            state_next     = tccs_pkg::ST_FILL;
                        end
                        tccs_pkg::OP_READ:
                        begin
                            state_next = tccs_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = tccs_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            tccs_pkg::ST_READ:
            begin
                res_cell_next = mem_rdata_reg;
                state_next    = tccs_pkg::ST_EMIT;
            end
            tccs_pkg::ST_COPY:
            begin
                // read one row below, write the previous read one row up
                mem_raddr = scan_reg;
                if (copy_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = copy_addr_reg;
                    mem_wdata = mem_rdata_reg;
                end
                copy_pend_next = 1'b1;
                copy_addr_next = scan_reg - tccs_pkg::ROW_STRIDE;
                if (scan_reg == tccs_pkg::CELL_LAST)
                begin
                    scan_next      = tccs_pkg::LAST_ROW_BASE;
                    fill_attr_next = text_color;
                    fill_emit_next = 1'b1;
                    state_next     = tccs_pkg::ST_FILL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            tccs_pkg::ST_FILL:
            begin
                mem_we = 1'b1;
                if (copy_pend_reg)
                begin
                    // drain the last copy before blanking
                    mem_waddr      = copy_addr_reg;
                    mem_wdata      = mem_rdata_reg;
                    copy_pend_next = 1'b0;
                end
                else if (scan_reg == tccs_pkg::CELL_LAST)
                begin
                    state_next = fill_emit_reg ? tccs_pkg::ST_EMIT : tccs_pkg::ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            tccs_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = row_reg;
                    out_col_next    = col_reg;
                    out_cell_next   = res_cell_reg;
                    out_scroll_next = res_scroll_reg;
                    state_next      = tccs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tccs_pkg::ST_FILL;
            row_reg       <= '0;
            col_reg       <= '0;
            scan_reg      <= '0;
            copy_pend_reg <= 1'b0;
            fill_attr_reg <= tccs_pkg::DEFAULT_COLOR;
            fill_emit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            scan_reg      <= scan_next;
            copy_pend_reg <= copy_pend_next;
            fill_attr_reg <= fill_attr_next;
            fill_emit_reg <= fill_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg  <= copy_addr_next;
        res_cell_reg   <= res_cell_next;
        res_scroll_reg <= res_scroll_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_cell_reg   <= out_cell_next;
        out_scroll_reg <= out_scroll_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cell_mem[mem_raddr];
    end

endmodule

`default_nettype wire

### src/text_console_cursor_scroll_top.sv
// ============================================================================
// text_console_cursor_scroll_top - text mode console engine
// character cell store with cursor, newline, wrap, scroll and clear
// ============================================================================
// the single back-end sequencer finishes each command before it takes the next one
// scroll: rows are copied up one cell per cycle, then the bottom row is blanked
// clear: blanks the store with one store write per cycle and homes the cursor
// reset: a clearing pass fills the store with grey blanks;
// in_stall is high during it, configuration writes are still taken
`default_nettype none

module text_console_cursor_scroll_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tccs_pkg::REQ_W-1:0]     req_type,
    input  wire logic [tccs_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tccs_pkg::ADDR_W-1:0]    cell_index,

    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [tccs_pkg::ROW_W-1:0]          cursor_row,
    output logic [tccs_pkg::COL_W-1:0]          cursor_col,
    output logic [tccs_pkg::CELL_W-1:0]         cell_value,
    output logic                                scrolled,

    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tccs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tccs_pkg::PDATA_W-1:0]   pwdata,
    output logic [tccs_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [tccs_pkg::ATTR_W-1:0] text_color_reg, text_color_next;
    logic                        cfg_write;
    logic                        color_sel;

    logic                        q_push;
    logic                        q_pop;
    logic                        q_not_empty;
    logic                        q_full;
    tccs_pkg::cmd_t              front_cmd;
    tccs_pkg::cmd_t              head_cmd;
    logic                        init_busy;

    // ------------------------------------------------------------------
    // configuration registers: word address selects the register,
    // byte offset bits are ignored
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign color_sel = (paddr[tccs_pkg::PADDR_W-1] == tccs_pkg::REG_TEXT_COLOR);
    assign cfg_write = psel && penable && pwrite && pready && color_sel;

    always_comb
    begin
        text_color_next = text_color_reg;
        if (cfg_write)
        begin
            text_color_next = pwdata[tccs_pkg::ATTR_W-1:0];
        end
        prdata = color_sel ?
                 tccs_pkg::PDATA_W'(text_color_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tccs_pkg::DEFAULT_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    // ------------------------------------------------------------------
    // front: request intake and classification
    // ------------------------------------------------------------------
    tccs_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .q_full     (q_full),
        .hold       (init_busy),
        .push       (q_push),
        .cmd        (front_cmd)
    );

    // ------------------------------------------------------------------
    // short queue between intake and execution
    // ------------------------------------------------------------------
    tccs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head_cmd  (head_cmd)
    );

    // ------------------------------------------------------------------
    // back: screen store, cursor and result register
    // ------------------------------------------------------------------
    tccs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_not_empty),
        .cmd        (head_cmd),
        .cmd_pop    (q_pop),
        .text_color (text_color_reg),
        .init_busy  (init_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_value (cell_value),
        .scrolled   (scrolled)
    );

endmodule

`default_nettype wire

### src/tccs_checker.sv
// ============================================================================
// tccs_checker - port level checks for the text console
// watches result channel and reset intake behavior
// ============================================================================
`default_nettype none

module tccs_checker
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_stall,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [tccs_pkg::ROW_W-1:0]   cursor_row,
    input  wire logic [tccs_pkg::COL_W-1:0]   cursor_col,
    input  wire logic [tccs_pkg::CELL_W-1:0]  cell_value,
    input  wire logic                         scrolled
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_value)
            && $stable(cursor_row) && $stable(cursor_col) && $stable(scrolled))
        else $error("stalled result changed");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_row <= tccs_pkg::ROW_LAST)
            && (cursor_col <= tccs_pkg::COL_LAST))
        else $error("cursor off screen");

    // a scroll leaves the cursor on the bottom row and reads nothing
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cursor_row == tccs_pkg::ROW_LAST)
            && (cell_value == '0))
        else $error("scroll result inconsistent");

    // a scroll only happens at column zero
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> (cursor_col == '0))
        else $error("scroll left cursor off column zero");

    // clearing pass after reset holds off requests
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("request taken during clearing pass");

endmodule

bind text_console_cursor_scroll_top tccs_checker u_tccs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_value (cell_value),
    .scrolled   (scrolled)
);

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for the text console cursor and scroll engine
// a short table of directed requests with some results typed in by hand,
// then random request traffic (text runs, newline bursts, cell reads, clears,
// noise) under several idle and stall mixes and text colors; every result
// transfer is checked field by field against its typed result or a cycle-free console model
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // the request code that the block has no use for
    localparam logic [tccs_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // byte address of the color register on the configuration port
    localparam logic [tccs_pkg::PADDR_W-1:0] TEXT_COLOR_ADDR =
        tccs_pkg::PADDR_W'(4 * tccs_pkg::REG_TEXT_COLOR);

    // one result transfer as the block presents it
    typedef struct packed {
        logic [tccs_pkg::ROW_W-1:0]  row;
        logic [tccs_pkg::COL_W-1:0]  col;
        logic [tccs_pkg::CELL_W-1:0] cell_val;
        logic                        scr;
    } console_result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [tccs_pkg::REQ_W-1:0]  req;
        logic [tccs_pkg::CHAR_W-1:0] ch;
        logic [tccs_pkg::ADDR_W-1:0] idx;
        logic                        typed;
        console_result_t             want;
    } console_step_t;

    localparam console_result_t NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 21;

    // directed requests, starting from reset (grey on black, cursor home)
    localparam console_step_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        // reads of the first and last cell after the clearing pass
        '{tccs_pkg::REQ_READ,  8'h00, 11'd0,    1'b1, '{5'd0, 7'd0, 16'h0720, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'hFF, 11'd1999, 1'b1, '{5'd0, 7'd0, 16'h0720, 1'b0}},
        // reads past the end of the store give zero
        '{tccs_pkg::REQ_READ,  8'h00, 11'd2000, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'hFF, 11'd2047, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        // lowest and highest character bytes
        '{tccs_pkg::REQ_PUT,   8'h00, 11'd2047, 1'b1, '{5'd0, 7'd1, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_PUT,   8'hFF, 11'd0,    1'b1, '{5'd0, 7'd2, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'h55, 11'd0,    1'b1, '{5'd0, 7'd2, 16'h0700, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'hAA, 11'd1,    1'b1, '{5'd0, 7'd2, 16'h07FF, 1'b0}},
        // unused request type leaves everything alone
        '{REQ_UNUSED,          8'hFF, 11'd2047, 1'b1, '{5'd0, 7'd2, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_PUT,   8'h41, 11'd5,    1'b0, NO_RESULT},
        // newline, then the bytes either side of it
        '{tccs_pkg::REQ_PUT,   8'h0A, 11'd0,    1'b1, '{5'd1, 7'd0, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_PUT,   8'h0B, 11'd0,    1'b1, '{5'd1, 7'd1, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_PUT,   8'h09, 11'd3,    1'b0, NO_RESULT},
        '{tccs_pkg::REQ_READ,  8'h00, 11'd80,   1'b1, '{5'd1, 7'd2, 16'h070B, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'h00, 11'd2,    1'b1, '{5'd1, 7'd2, 16'h0741, 1'b0}},
        '{REQ_UNUSED,          8'h0A, 11'd81,   1'b0, NO_RESULT},
        // clear homes the cursor and never reports a scroll
        '{tccs_pkg::REQ_CLEAR, 8'hFF, 11'h7FF,  1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'h00, 11'd80,   1'b1, '{5'd0, 7'd0, 16'h0720, 1'b0}},
        '{tccs_pkg::REQ_READ,  8'h00, 11'd2,    1'b0, NO_RESULT},
        '{tccs_pkg::REQ_PUT,   8'h0A, 11'd1999, 1'b0, NO_RESULT},
        '{tccs_pkg::REQ_READ,  8'h0A, 11'd1999, 1'b0, NO_RESULT}
    };

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic [tccs_pkg::REQ_W-1:0]     req_type   = '0;
    logic [tccs_pkg::CHAR_W-1:0]    char_code  = '0;
    logic [tccs_pkg::ADDR_W-1:0]    cell_index = '0;

    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic [tccs_pkg::ROW_W-1:0]     cursor_row;
    logic [tccs_pkg::COL_W-1:0]     cursor_col;
    logic [tccs_pkg::CELL_W-1:0]    cell_value;
    logic                           scrolled;

    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [tccs_pkg::PADDR_W-1:0]   paddr   = '0;
    logic [tccs_pkg::PDATA_W-1:0]   pwdata  = '0;
    logic [tccs_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    text_console_cursor_scroll_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_value (cell_value),
        .scrolled   (scrolled),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // console model: its own copy of the screen, cursor and color
    // ------------------------------------------------------------------------
    logic [tccs_pkg::CELL_W-1:0] screen_copy [tccs_pkg::CELL_COUNT];
    int                          cur_row;
    int                          cur_col;
    logic [tccs_pkg::ATTR_W-1:0] cur_color;

    console_result_t   pending_results [$];   // expected results, oldest first
    int                fail_count    = 0;
    int                requests_sent = 0;
    int                idle_pct      = 0;     // sender idle chance per cycle
    int                stall_pct     = 0;     // receiver stall chance per cycle

    // blank every cell in the current color and home the cursor
    function automatic void blank_screen_copy();
        int i;
        for (i = 0; i < tccs_pkg::CELL_COUNT; i++)
            screen_copy[i] = {cur_color, tccs_pkg::BLANK_CODE};
        cur_row = 0;
        cur_col = 0;
    endfunction

    // apply one request to the model and return the result it should give
    function automatic console_result_t console_apply(
        input logic [tccs_pkg::REQ_W-1:0]  req,
        input logic [tccs_pkg::CHAR_W-1:0] ch,
        input logic [tccs_pkg::ADDR_W-1:0] idx
    );
        console_result_t r;
        int              i;
        r = '0;
        case (req)
            tccs_pkg::REQ_PUT:
            begin
                if (ch == tccs_pkg::NEWLINE_CODE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else
                begin
                    screen_copy[cur_row * tccs_pkg::SCREEN_WIDTH + cur_col] = {cur_color, ch};
                    cur_col++;
                    // wrap at the right edge
                    if (cur_col >= tccs_pkg::SCREEN_WIDTH)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // fell off the bottom: move all rows up and blank the last one
                if (cur_row >= tccs_pkg::SCREEN_HEIGHT)
                begin
                    for (i = 0;
                         i < (tccs_pkg::SCREEN_HEIGHT - 1) * tccs_pkg::SCREEN_WIDTH; i++)
                        screen_copy[i] = screen_copy[i + tccs_pkg::SCREEN_WIDTH];
                    for (i = (tccs_pkg::SCREEN_HEIGHT - 1) * tccs_pkg::SCREEN_WIDTH;
                         i < tccs_pkg::CELL_COUNT; i++)
                        screen_copy[i] = {cur_color, tccs_pkg::BLANK_CODE};
                    cur_row = tccs_pkg::SCREEN_HEIGHT - 1;
                    r.scr   = 1'b1;
                end
            end
            tccs_pkg::REQ_CLEAR:
                blank_screen_copy();
            tccs_pkg::REQ_READ:
                if (idx < tccs_pkg::CELL_COUNT)
                    r.cell_val = screen_copy[idx];
            default:
                ;
        endcase
        r.row = tccs_pkg::ROW_W'(cur_row);
        r.col = tccs_pkg::COL_W'(cur_col);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // outputs are registered, so the values seen here are the pre-edge ones
    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("result with nothing expected, row %0d col %0d",
                                       cursor_row, cursor_col));
            else
            begin
                want = pending_results.pop_front();
                if (cursor_row !== want.row)
                    note_failure($sformatf("cursor_row got %0d want %0d",
                                           cursor_row, want.row));
                if (cursor_col !== want.col)
                    note_failure($sformatf("cursor_col got %0d want %0d",
                                           cursor_col, want.col));
                if (cell_value !== want.cell_val)
                    note_failure($sformatf("cell_value got %04h want %04h",
                                           cell_value, want.cell_val));
                if (scrolled !== want.scr)
                    note_failure($sformatf("scrolled got %0b want %0b",
                                           scrolled, want.scr));
            end
        end
    end

    // receiver side: random stall, changed at the falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------------
    // stimulus tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    // one request transfer; idle cycles before it carry junk payload
    task automatic send_request(
        input logic [tccs_pkg::REQ_W-1:0]  req,
        input logic [tccs_pkg::CHAR_W-1:0] ch,
        input logic [tccs_pkg::ADDR_W-1:0] idx,
        input logic                        typed,
        input console_result_t             typed_want
    );
        console_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid   <= 1'b0;
            req_type   <= tccs_pkg::REQ_W'($urandom);
            char_code  <= tccs_pkg::CHAR_W'($urandom);
            cell_index <= tccs_pkg::ADDR_W'($urandom);
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge
        predicted = console_apply(req, ch, idx);
        pending_results.push_back(typed ? typed_want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_checked(
        input logic [tccs_pkg::REQ_W-1:0]  req,
        input logic [tccs_pkg::CHAR_W-1:0] ch,
        input logic [tccs_pkg::ADDR_W-1:0] idx
    );
        send_request(req, ch, idx, 1'b0, NO_RESULT);
    endtask

    // hold the request side quiet until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // setup cycle, then access cycle; written at the edge with pready high
    task automatic write_text_color(input logic [tccs_pkg::ATTR_W-1:0] color);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_COLOR_ADDR;
        pwdata  <= tccs_pkg::PDATA_W'(color);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cur_color = color;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random traffic in bursts: text runs, newline bursts, reads, clears, noise
    task automatic run_traffic(input int count);
        int first;
        int kind;
        int burst;
        int k;
        int pick;
        first = requests_sent;
        while (requests_sent - first < count)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                // a run of text, now and then long enough to wrap
                burst = ($urandom_range(9) == 0) ? $urandom_range(60, 100)
                                                 : $urandom_range(1, 40);
                for (k = 0; k < burst; k++)
                    send_checked(tccs_pkg::REQ_PUT,
                                 ($urandom_range(99) < 15) ?
                                     tccs_pkg::CHAR_W'($urandom) :
                                     tccs_pkg::CHAR_W'($urandom_range(32, 126)),
                                 tccs_pkg::ADDR_W'($urandom));
                if ($urandom_range(1) == 1)
                    send_checked(tccs_pkg::REQ_PUT, tccs_pkg::NEWLINE_CODE,
                                 tccs_pkg::ADDR_W'($urandom));
            end
            else if (kind < 55)
            begin
                // newlines, sometimes enough to run off the bottom
                burst = ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 4);
                for (k = 0; k < burst; k++)
                    send_checked(tccs_pkg::REQ_PUT, tccs_pkg::NEWLINE_CODE,
                                 tccs_pkg::ADDR_W'($urandom));
            end
            else if (kind < 80)
            begin
                // read back, half of the time on the cursor row
                burst = $urandom_range(1, 8);
                for (k = 0; k < burst; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        send_checked(tccs_pkg::REQ_READ, tccs_pkg::CHAR_W'($urandom),
                                     tccs_pkg::ADDR_W'(cur_row * tccs_pkg::SCREEN_WIDTH
                                         + $urandom_range(tccs_pkg::SCREEN_WIDTH - 1)));
                    else if (pick < 95)
                        send_checked(tccs_pkg::REQ_READ, tccs_pkg::CHAR_W'($urandom),
                                     tccs_pkg::ADDR_W'(
                                         $urandom_range(tccs_pkg::CELL_COUNT - 1)));
                    else
                        send_checked(tccs_pkg::REQ_READ, tccs_pkg::CHAR_W'($urandom),
                                     tccs_pkg::ADDR_W'($urandom_range(
                                         tccs_pkg::CELL_COUNT,
                                         (1 << tccs_pkg::ADDR_W) - 1)));
                end
            end
            else if (kind < 82)
                send_checked(tccs_pkg::REQ_CLEAR, tccs_pkg::CHAR_W'($urandom),
                             tccs_pkg::ADDR_W'($urandom));
            else
            begin
                // anything the fields allow, unused request type included
                burst = $urandom_range(1, 4);
                for (k = 0; k < burst; k++)
                    send_checked(tccs_pkg::REQ_W'($urandom), tccs_pkg::CHAR_W'($urandom),
                                 tccs_pkg::ADDR_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        cur_color = tccs_pkg::DEFAULT_COLOR;
        blank_screen_copy();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling; waits out the clearing pass via in_stall
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED_STEPS[i].req, DIRECTED_STEPS[i].ch,
                         DIRECTED_STEPS[i].idx, DIRECTED_STEPS[i].typed,
                         DIRECTED_STEPS[i].want);

        // black on black, both sides running flat out
        wait_drained();
        write_text_color(8'h00);
        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(250);

        // white on white, sender mostly idle, with a full drain half way
        wait_drained();
        write_text_color(8'hFF);
        idle_pct  = 65;
        stall_pct = 0;
        run_traffic(125);
        wait_drained();
        run_traffic(125);

        // random color, receiver mostly stalled
        wait_drained();
        write_text_color(tccs_pkg::ATTR_W'($urandom));
        idle_pct  = 0;
        stall_pct = 65;
        run_traffic(250);

        // random color, light idling on both sides
        wait_drained();
        write_text_color(tccs_pkg::ATTR_W'($urandom));
        idle_pct  = 9;
        stall_pct = 9;
        run_traffic(250);

        wait_drained();
        stall_pct = 0;
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #400_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
